// ===== rtl/tccw_pkg.sv =====
// Shared types, codes and constants of the text console character writer.
package tccw_pkg;

  // field widths
  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 7;
  localparam int COLOR_W   = 4;
  localparam int CELL_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  // default geometry
  localparam int COLS_DEF      = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 8;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // write data select
  typedef enum logic [2:0] {
    WD_CHAR  = 3'd0,
    WD_SPACE = 3'd1,
    WD_BLANK = 3'd2,
    WD_ZERO  = 3'd3,
    WD_COPY  = 3'd4
  } wd_sel_e;

  // write address select
  typedef enum logic [1:0] {
    WA_CUR   = 2'd0,
    WA_CURM1 = 2'd1,
    WA_CNT   = 2'd2,
    WA_CNTM1 = 2'd3
  } wa_sel_e;

  // read address select
  typedef enum logic {
    RA_CELL = 1'b0,
    RA_COPY = 1'b1
  } ra_sel_e;

  typedef enum logic [2:0] {
    CUR_HOLD   = 3'd0,
    CUR_HOME   = 3'd1,
    CUR_CR     = 3'd2,
    CUR_LF     = 3'd3,
    CUR_ADV    = 3'd4,
    CUR_BACK   = 3'd5,
    CUR_BOTTOM = 3'd6
  } cur_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_INC  = 2'd2
  } cnt_op_e;

  typedef struct packed {
    logic    item_load;
    logic    wr_en;
    wd_sel_e wd_sel;
    wa_sel_e wa_sel;
    ra_sel_e ra_sel;
    cur_op_e cur_op;
    cnt_op_e cnt_op;
    logic    rd_load;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  is_cr;
    logic  is_lf;
    logic  is_tab;
    logic  is_bs;
    logic  row_last;
    logic  col_zero;
    logic  tab_stop;
    logic  rd_in_range;
    logic  cnt_copy_end;
    logic  cnt_last_cell;
  } dp_sts_t;

endpackage

// ===== rtl/tccw_dp.sv =====
// Datapath: screen memory, cursor, counters, colors and result register.
module tccw_dp
  import tccw_pkg::*;
#(
  parameter int COLS      = COLS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [ROW_W-1:0]     cell_row_i,
  input  logic [COL_W-1:0]     cell_col_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output logic [CHAR_W-1:0]    read_char_o,
  output logic [COLOR_W-1:0]   read_fore_o,
  output logic [COLOR_W-1:0]   read_back_o,
  output logic [ROW_W-1:0]     cursor_row_o,
  output logic [COL_W-1:0]     cursor_col_o,
  output logic                 scrolled_o
);

  localparam int NCELLS = ROWS * COLS;
  localparam int NCOPY  = NCELLS - COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLS);
  localparam int MW     = $clog2(TAB_WIDTH);

  // latched item
  kind_e             kind_q;
  logic [CHAR_W-1:0] ch_q;
  logic [ROW_W-1:0]  rrow_q;
  logic [COL_W-1:0]  rcol_q;

  // cursor, column modulo tab width, sweep counter
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [MW-1:0] mod_q, mod_d;
  logic [AW-1:0] cnt_q, cnt_d;

  logic [COLOR_W-1:0] fore_q, back_q;
  logic [CELL_W-1:0]  rd_q;
  logic               scr_q;

  logic [CELL_W-1:0] mem_q [NCELLS];
  logic [CELL_W-1:0] rdata_q;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]     waddr, raddr, cur_addr, cell_addr;

  logic [CHAR_W-1:0]  out_char_q;
  logic [COLOR_W-1:0] out_fore_q, out_back_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [COL_W-1:0]   out_col_q;
  logic               out_scr_q;

  logic col_last, row_last, mod_last;

  assign col_last  = (int'(col_q) == COLS - 1);
  assign row_last  = (int'(row_q) == ROWS - 1);
  assign mod_last  = (int'(mod_q) == TAB_WIDTH - 1);
  assign cur_addr  = AW'(int'(row_q) * COLS + int'(col_q));
  assign cell_addr = AW'(int'(rrow_q) * COLS + int'(rcol_q));

  always_comb begin
    sts_o.kind          = kind_q;
    sts_o.is_cr         = (ch_q == CH_CR);
    sts_o.is_lf         = (ch_q == CH_LF);
    sts_o.is_tab        = (ch_q == CH_TAB);
    sts_o.is_bs         = (ch_q == CH_BS);
    sts_o.row_last      = row_last;
    sts_o.col_zero      = (col_q == '0);
    sts_o.tab_stop      = col_last || mod_last;
    sts_o.rd_in_range   = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLS);
    sts_o.cnt_copy_end  = (int'(cnt_q) == NCOPY);
    sts_o.cnt_last_cell = (int'(cnt_q) == NCELLS - 1);
  end

  // cursor update
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    mod_d = mod_q;
    case (cmd_i.cur_op)
      CUR_HOLD: ;
      CUR_HOME: begin
        row_d = '0;
        col_d = '0;
        mod_d = '0;
      end
      CUR_CR: begin
        col_d = '0;
        mod_d = '0;
      end
      CUR_LF: begin
        row_d = row_q + RW'(1);
        col_d = '0;
        mod_d = '0;
      end
      CUR_ADV: begin
        if (col_last) begin
          col_d = '0;
          mod_d = '0;
          row_d = row_last ? '0 : row_q + RW'(1);
        end else begin
          col_d = col_q + CW'(1);
          mod_d = mod_last ? '0 : mod_q + MW'(1);
        end
      end
      CUR_BACK: begin
        col_d = col_q - CW'(1);
        mod_d = (mod_q == '0) ? MW'(TAB_WIDTH - 1) : mod_q - MW'(1);
      end
      CUR_BOTTOM: begin
        row_d = RW'(ROWS - 1);
        col_d = '0;
        mod_d = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_CLR: cnt_d = '0;
      CNT_INC: cnt_d = cnt_q + AW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      mod_q  <= '0;
      cnt_q  <= '0;
      fore_q <= '0;
      back_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      mod_q <= mod_d;
      cnt_q <= cnt_d;
      if (cfg_we_i && cfg_index_i == CFG_FORE) begin
        fore_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_BACK) begin
        back_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      kind_q <= kind_e'(kind_i);
      ch_q   <= char_code_i;
      rrow_q <= cell_row_i;
      rcol_q <= cell_col_i;
      rd_q   <= '0;
      scr_q  <= 1'b0;
    end else begin
      if (cmd_i.rd_load) begin
        rd_q <= rdata_q;
      end
      if (cmd_i.cur_op == CUR_BOTTOM) begin
        scr_q <= 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd_i.wd_sel)
      WD_CHAR:  wdata = {back_q, fore_q, ch_q};
      WD_SPACE: wdata = {back_q, fore_q, CH_SPACE};
      WD_BLANK: wdata = {back_q, fore_q, CH_NUL};
      WD_COPY:  wdata = rdata_q;
      default:  wdata = '0;
    endcase
    case (cmd_i.wa_sel)
      WA_CUR:   waddr = cur_addr;
      WA_CURM1: waddr = cur_addr - AW'(1);
      WA_CNT:   waddr = cnt_q;
      default:  waddr = cnt_q - AW'(1);
    endcase
    case (cmd_i.ra_sel)
      RA_COPY: raddr = AW'(int'(cnt_q) + COLS);
      default: raddr = cell_addr;
    endcase
  end

  // screen store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_char_q <= rd_q[7:0];
      out_fore_q <= rd_q[11:8];
      out_back_q <= rd_q[15:12];
      out_row_q  <= ROW_W'(row_q);
      out_col_q  <= COL_W'(col_q);
      out_scr_q  <= scr_q;
    end
  end

  assign read_char_o  = out_char_q;
  assign read_fore_o  = out_fore_q;
  assign read_back_o  = out_back_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign scrolled_o   = out_scr_q;

endmodule

// ===== rtl/tccw_ctrl.sv =====
// Controller: sequences each item over the datapath and owns the handshakes.
module tccw_ctrl
  import tccw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_EXEC  = 8'b0000_0100,
    ST_CLEAR = 8'b0000_1000,
    ST_COPY  = 8'b0001_0000,
    ST_FILL  = 8'b0010_0000,
    ST_READ  = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.wd_sel     = WD_ZERO;
    cmd_o.wa_sel     = WA_CNT;
    cmd_o.ra_sel     = RA_CELL;
    cmd_o.cur_op     = CUR_HOLD;
    cmd_o.cnt_op     = CNT_HOLD;
    case (state_q)
      ST_INIT: begin
        // post-reset sweep: every cell to zero
        cmd_o.wr_en  = 1'b1;
        cmd_o.wd_sel = WD_ZERO;
        cmd_o.cnt_op = CNT_INC;
        if (sts_i.cnt_last_cell) begin
          cmd_o.cnt_op = CNT_CLR;
          state_d      = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_RESP;
        case (sts_i.kind)
          KIND_PUT: begin
            if (sts_i.is_cr) begin
              cmd_o.cur_op = CUR_CR;
            end else if (sts_i.is_lf) begin
              if (sts_i.row_last) begin
                state_d = ST_COPY;
              end else begin
                cmd_o.cur_op = CUR_LF;
              end
            end else if (sts_i.is_tab) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wd_sel = WD_SPACE;
              cmd_o.wa_sel = WA_CUR;
              cmd_o.cur_op = CUR_ADV;
              if (!sts_i.tab_stop) begin
                state_d = ST_EXEC;
              end
            end else if (sts_i.is_bs) begin
              if (!sts_i.col_zero) begin
                cmd_o.wr_en  = 1'b1;
                cmd_o.wd_sel = WD_SPACE;
                cmd_o.wa_sel = WA_CURM1;
                cmd_o.cur_op = CUR_BACK;
              end
            end else begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wd_sel = WD_CHAR;
              cmd_o.wa_sel = WA_CUR;
              cmd_o.cur_op = CUR_ADV;
            end
          end
          KIND_CLEAR: state_d = ST_CLEAR;
          KIND_READ: begin
            cmd_o.ra_sel = RA_CELL;
            if (sts_i.rd_in_range) begin
              state_d = ST_READ;
            end
          end
          default: ;
        endcase
      end
      ST_CLEAR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wd_sel = WD_BLANK;
        cmd_o.cnt_op = CNT_INC;
        if (sts_i.cnt_last_cell) begin
          cmd_o.cnt_op = CNT_CLR;
          cmd_o.cur_op = CUR_HOME;
          state_d      = ST_RESP;
        end
      end
      ST_COPY: begin
        // read cell k+COLS while writing back the cell read last cycle; the
        // first cycle's write lands past the last cell or in the bottom row,
        // which the fill rewrites
        cmd_o.ra_sel = RA_COPY;
        cmd_o.wd_sel = WD_COPY;
        cmd_o.wa_sel = WA_CNTM1;
        cmd_o.wr_en  = 1'b1;
        if (sts_i.cnt_copy_end) begin
          cmd_o.cnt_op = CNT_HOLD;
          state_d      = ST_FILL;
        end else begin
          cmd_o.cnt_op = CNT_INC;
        end
      end
      ST_FILL: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wd_sel = WD_SPACE;
        cmd_o.wa_sel = WA_CNT;
        cmd_o.cnt_op = CNT_INC;
        if (sts_i.cnt_last_cell) begin
          cmd_o.cnt_op = CNT_CLR;
          cmd_o.cur_op = CUR_BOTTOM;
          state_d      = ST_RESP;
        end
      end
      ST_READ: begin
        cmd_o.rd_load = 1'b1;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/text_console_char_writer_core.sv =====
// Top level of the text console character writer.
//
//  channel | valid / ready          | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | kind_i char_code_i cell_row_i cell_col_i
//  out     | out_valid_o/out_ready_i | read_char/fore/back, cursor_row/col, scrolled
//  cfg     | cfg_we_i (no wait)      | cfg_index_i cfg_data_i
//
// A tab writes spaces up to the next tab stop, at most TAB_WIDTH of them. Clear and
// scrolling LF are paced by the single write port of the screen store, one cell per cycle.
// After reset the store is swept to zero with in_ready_o low.
// A result may wait in the output register while the next item is worked on.
module text_console_char_writer_core
  import tccw_pkg::*;
#(
  parameter int COLS      = COLS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [ROW_W-1:0]     cell_row_i,
  input  logic [COL_W-1:0]     cell_col_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CHAR_W-1:0]    read_char_o,
  output logic [COLOR_W-1:0]   read_fore_o,
  output logic [COLOR_W-1:0]   read_back_o,
  output logic [ROW_W-1:0]     cursor_row_o,
  output logic [COL_W-1:0]     cursor_col_o,
  output logic                 scrolled_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tccw_dp #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_char_o  (read_char_o),
    .read_fore_o  (read_fore_o),
    .read_back_o  (read_back_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o)
  );

`ifndef ASSERT_OFF
  // one item at a time: busy right after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous item still in work");

  // a scroll always leaves the cursor at the start of the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cursor_col_o == '0 && cursor_row_o == ROW_W'(ROWS - 1))
    else $error("scroll result with cursor off the bottom row start");

  // every result reports a cursor column inside the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(cursor_col_o) < COLS)
    else $error("cursor column out of range");
`endif

endmodule
